// ===== design/binary_image_lane_edge_tracker_assert.svh =====
// ---------------------------------------------------------------------------
// Lane edge tracker assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ---------------------------------------------------------------------------
`ifndef BINARY_IMAGE_LANE_EDGE_TRACKER_ASSERT_SVH
`define BINARY_IMAGE_LANE_EDGE_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define BLET_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lane edge tracker assertion failed");
`define BLET_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lane edge tracker forbidden condition");
`else
`define BLET_ASSERT(lbl, clk, rst, prop)
`define BLET_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== design/blet_pkg.sv =====
// ---------------------------------------------------------------------------
// Lane edge tracker package
// Shared constants, types and helpers of the lane edge tracker.
// ---------------------------------------------------------------------------
package blet_pkg;

   localparam int IMG_WIDTH  = 160;
   localparam int IMG_HEIGHT = 120;
   localparam int PIX_DEPTH  = IMG_WIDTH * IMG_HEIGHT;
   localparam int PIX_AW     = $clog2(PIX_DEPTH);
   localparam int ROW_AW     = $clog2(IMG_HEIGHT);
   localparam int CW         = 11;
   localparam int WIN_LEN    = 13;

   typedef logic signed [CW-1:0] scol_type;

   localparam logic [7:0] START_LEFTISH   = 8'd52;
   localparam logic [7:0] START_RIGHTISH  = 8'd108;
   localparam logic [7:0] START_CENTER    = 8'd80;
   localparam logic [7:0] CENTER_LOW      = 8'd78;
   localparam logic [7:0] CENTER_HIGH     = 8'd82;
   localparam logic [6:0] TRACK_FIRST_ROW = 7'd116;
   localparam logic [6:0] SEED_LAST_ROW   = 7'(IMG_HEIGHT - 3);
   localparam logic [7:0] CNT_LEFT_COL    = 8'd79;
   localparam logic [7:0] CNT_RIGHT_COL   = 8'd155;
   localparam logic [4:0] CNT_LAST_STEP   = 5'd18;
   localparam logic [1:0] CNT_LAST_ROW    = 2'd2;
   localparam logic [9:0] DIV3_MUL        = 10'd683;
   localparam int         DIV3_SHIFT      = 11;

   localparam logic [1:0] ST_FOUND      = 2'd0;
   localparam logic [1:0] ST_LOST_WHITE = 2'd1;
   localparam logic [1:0] ST_LOST_BLACK = 2'd2;

   localparam logic [2:0] CSR_LEFT_LIMIT    = 3'd0;
   localparam logic [2:0] CSR_RIGHT_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_TOP_ROW       = 3'd2;
   localparam logic [2:0] CSR_TRACK_WINDOW  = 3'd3;
   localparam logic [2:0] CSR_REFIND_WINDOW = 3'd4;

   typedef enum logic [2:0] {
      PAT_SEED_R, PAT_SEED_L, PAT_TRK_L, PAT_CTR_L, PAT_TRK_R, PAT_CTR_R
   } pat_type;

   typedef enum logic [4:0] {
      FSM_IDLE, FSM_CNT, FSM_CNT_END, FSM_SEED_RD, FSM_SEED_R, FSM_SEED_L,
      FSM_SEED_WR, FSM_BASE, FSM_TRK_L, FSM_REF_L, FSM_CTR_L, FSM_LOST_L,
      FSM_LOST_LW, FSM_TRK_R, FSM_REF_R, FSM_CTR_R, FSM_LOST_R, FSM_LOST_RW,
      FSM_ROW_WR, FSM_FINISH
   } state_type;

   typedef struct packed {
      logic     go;
      pat_type  pat;
      scol_type c0;
      scol_type bound;
      logic [6:0] row;
   } scan_req_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      logic     found;
      scol_type x;
   } scan_rsp_type;

   typedef struct packed {
      logic [7:0] left_edge;
      logic [7:0] right_edge;
      logic [1:0] left_status;
      logic [1:0] right_status;
   } edge_entry_type;

   function automatic logic [PIX_AW-1:0] pix_addr(input logic [6:0] row,
                                                   input logic [7:0] col);
      pix_addr = PIX_AW'(int'(row) * IMG_WIDTH + int'(col));
   endfunction

   function automatic logic in_frame(input scol_type c);
      in_frame = (c >= 0) && (c < scol_type'(IMG_WIDTH));
   endfunction

endpackage

// ===== design/blet_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single port RAM
// One access per cycle, registered read data, read before write.
// ---------------------------------------------------------------------------
module blet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/blet_scan.sv =====
// ---------------------------------------------------------------------------
// Lane edge tracker column scanner
// Streams one pixel a cycle from the frame memory into a 13 pixel window
// and tests one candidate column a cycle against an edge pattern.
// ---------------------------------------------------------------------------
module blet_scan import blet_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scan_req_type      sreq,
   output scan_rsp_type      srsp,
   output logic              pix_re,
   output logic [PIX_AW-1:0] pix_ra,
   input  logic              pix_q
);

   logic                run_ff;
   logic                done_ff;
   logic                found_ff;
   scol_type            x_ff;
   pat_type             pat_ff;
   scol_type            bound_ff;
   logic [6:0]          row_ff;
   scol_type            rp_ff;
   scol_type            cand_ff;
   logic [WIN_LEN-1:0]  win_ff;
   logic [3:0]          fill_ff;
   logic                arr_ff;
   logic                inb_ff;

   logic     dneg;
   logic     go_neg;
   scol_type step;
   logic     bit_in;
   logic     full;
   logic     inrange;
   logic     match;

   always_comb begin
      dneg    = pat_ff inside {PAT_SEED_L, PAT_TRK_L, PAT_CTR_L};
      go_neg  = sreq.pat inside {PAT_SEED_L, PAT_TRK_L, PAT_CTR_L};
      step    = dneg ? -scol_type'(1) : scol_type'(1);
      bit_in  = arr_ff & inb_ff & pix_q;
      full    = (fill_ff == 4'(WIN_LEN));
      inrange = dneg ? (cand_ff > bound_ff) : (cand_ff < bound_ff);
      // window bit 6 is the candidate column
      case (pat_ff)
         PAT_SEED_R: match = win_ff[10] & win_ff[8] & !win_ff[6] & !win_ff[4] &
                             !win_ff[2] & !win_ff[0];
         PAT_SEED_L: match = win_ff[4] & win_ff[5] & !win_ff[6] & !win_ff[7] &
                             !win_ff[8] & !win_ff[9];
         PAT_TRK_L:  match = win_ff[6] & win_ff[5] & win_ff[4] & !win_ff[7] &
                             !win_ff[8];
         PAT_CTR_L:  match = win_ff[6] & win_ff[5] & win_ff[4] & !win_ff[7] &
                             !win_ff[8] & !win_ff[9];
         PAT_TRK_R:  match = win_ff[6] & win_ff[7] & win_ff[8] & !win_ff[5] &
                             !win_ff[4];
         PAT_CTR_R:  match = win_ff[6] & win_ff[7] & win_ff[8] & !win_ff[5] &
                             !win_ff[4] & !win_ff[3];
         default:    match = 1'b0;
      endcase
      pix_re = run_ff;
      pix_ra = in_frame(rp_ff) ? pix_addr(row_ff, rp_ff[7:0]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         arr_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (sreq.go) begin
            run_ff   <= 1'b1;
            pat_ff   <= sreq.pat;
            bound_ff <= sreq.bound;
            row_ff   <= sreq.row;
            rp_ff    <= go_neg ? sreq.c0 + scol_type'(6) : sreq.c0 - scol_type'(6);
            cand_ff  <= sreq.c0;
            fill_ff  <= '0;
            arr_ff   <= 1'b0;
         end else if (run_ff) begin
            arr_ff <= 1'b1;
            inb_ff <= in_frame(rp_ff);
            rp_ff  <= rp_ff + step;
            if (full) begin
               if (!inrange || match) begin
                  run_ff   <= 1'b0;
                  done_ff  <= 1'b1;
                  found_ff <= inrange;
                  x_ff     <= cand_ff;
               end else begin
                  cand_ff <= cand_ff + step;
                  win_ff  <= dneg ? {win_ff[WIN_LEN-2:0], bit_in}
                                  : {bit_in, win_ff[WIN_LEN-1:1]};
               end
            end else if (arr_ff) begin
               fill_ff <= fill_ff + 4'd1;
               win_ff  <= dneg ? {win_ff[WIN_LEN-2:0], bit_in}
                               : {bit_in, win_ff[WIN_LEN-1:1]};
            end
         end
      end
   end

   assign srsp.busy  = run_ff;
   assign srsp.done  = done_ff;
   assign srsp.found = found_ff;
   assign srsp.x     = x_ff;

endmodule

// ===== design/binary_image_lane_edge_tracker.sv =====
// ---------------------------------------------------------------------------
// Binary image lane edge tracker
// Frame store plus a row by row left and right edge tracker.
// ---------------------------------------------------------------------------
// Pixel writes and row reads are taken one per cycle while busy is low; a
// row read returns its result on the rsp_ ports in the following cycle, and
// results cannot be held off. A write with frame_done raises busy for the
// whole tracking pass, which is bound by the single port of the pixel
// memory: column counting, then window searches, each made of launch, window
// fill and hand back and then the candidate columns tested one by one, up to
// three searches per side and row, plus a pixel read when an edge is lost and
// a row write for each row, over the three seed rows and rows 116 down to
// top_row. The pass ends with one frame result carrying the two bases. No
// clearing pass after reset.
`include "binary_image_lane_edge_tracker_assert.svh"

module binary_image_lane_edge_tracker import blet_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_op,
   input  logic [6:0] req_row,
   input  logic [7:0] req_col,
   input  logic       req_black,
   input  logic       req_frame_done,
   output logic       rsp_strobe,
   output logic       rsp_is_frame_result,
   output logic [7:0] rsp_left_edge,
   output logic [7:0] rsp_right_edge,
   output logic [1:0] rsp_left_status,
   output logic [1:0] rsp_right_status,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int EW = $bits(edge_entry_type);

   state_type  state_ff, state_in;
   logic       launched_ff, launched_in;
   logic [5:0] cl_ff, cl_in, cr_ff, cr_in;
   logic [1:0] cnt_row_ff, cnt_row_in;
   logic [4:0] cnt_j_ff, cnt_j_in;
   logic       cnt_side_ff, cnt_side_in;
   logic       cnt_pend_ff, cnt_pend_in;
   logic       cnt_pside_ff, cnt_pside_in;
   logic [6:0] y_ff, y_in;
   logic [7:0] el_ff, el_in, er_ff, er_in;
   logic [1:0] sl_ff, sl_in, sr_ff, sr_in;
   logic [9:0] suml_ff, suml_in, sumr_ff, sumr_in;
   logic [7:0] below_l_ff, below_l_in, below_r_ff, below_r_in;
   logic [7:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic [7:0] lbase_ff, lbase_in, rbase_ff, rbase_in;
   logic       inb_ff, inb_in;
   logic       rd_pend_ff, rd_pend_in;
   logic       rd_oor_ff, rd_oor_in;
   logic       rd_vld_ff, rd_vld_in;
   logic [5:0] left_limit_ff;
   logic [7:0] right_limit_ff;
   logic [6:0] top_row_ff;
   logic [5:0] track_window_ff;
   logic [5:0] refind_window_ff;
   logic       valid_ff [IMG_HEIGHT];

   logic              accept;
   logic              pix_en, pix_we, pix_wd, pix_q;
   logic [PIX_AW-1:0] pix_a;
   logic              edge_en, edge_we;
   logic [ROW_AW-1:0] edge_a;
   edge_entry_type    edge_wd, edge_q, ent;
   logic              valid_set;
   scan_req_type      sreq;
   scan_rsp_type      srsp;
   logic              scan_re;
   logic [PIX_AW-1:0] scan_ra;
   logic [7:0]        start_col;
   logic [7:0]        ctr;
   logic [5:0]        wdw;
   scol_type          lo_raw, hi_raw, lo, hi, ll_s, rl_s;
   logic [19:0]       lprod, rprod;
   logic              center_ok;
   logic [7:0]        cnt_col;

   blet_ram #(.WIDTH(1), .DEPTH(PIX_DEPTH)) u_pix_ram (
      .clock(clock), .en(pix_en), .we(pix_we), .addr(pix_a),
      .wdata(pix_wd), .rdata(pix_q)
   );

   blet_ram #(.WIDTH(EW), .DEPTH(IMG_HEIGHT)) u_edge_ram (
      .clock(clock), .en(edge_en), .we(edge_we), .addr(edge_a),
      .wdata(edge_wd), .rdata(edge_q)
   );

   blet_scan u_scan (
      .clock(clock), .reset(reset), .sreq(sreq), .srsp(srsp),
      .pix_re(scan_re), .pix_ra(scan_ra), .pix_q(pix_q)
   );

   assign busy   = (state_ff != FSM_IDLE);
   assign accept = start & !busy;

   always_comb begin
      start_col = START_CENTER;
      if (cr_ff > cl_ff) begin
         start_col = START_LEFTISH;
      end else if (cr_ff < cl_ff) begin
         start_col = START_RIGHTISH;
      end
      ent       = rd_vld_ff ? edge_q : '0;
      center_ok = (below_l_ff < CENTER_LOW) && (below_r_ff > CENTER_HIGH);
      cnt_col   = cnt_side_ff ? CNT_RIGHT_COL - {1'b0, cnt_j_ff, 2'b00}
                              : CNT_LEFT_COL - {1'b0, cnt_j_ff, 2'b00};
      lprod     = suml_ff * DIV3_MUL;
      rprod     = sumr_ff * DIV3_MUL;
      ll_s      = scol_type'({5'b0, left_limit_ff});
      rl_s      = scol_type'({3'b0, right_limit_ff});

      // search window around an earlier edge
      case (state_ff)
         FSM_TRK_L: begin ctr = prev_l_ff;  wdw = track_window_ff;  end
         FSM_REF_L: begin ctr = below_l_ff; wdw = refind_window_ff; end
         FSM_TRK_R: begin ctr = prev_r_ff;  wdw = track_window_ff;  end
         default:   begin ctr = below_r_ff; wdw = refind_window_ff; end
      endcase
      lo_raw = scol_type'({3'b0, ctr}) - scol_type'({5'b0, wdw});
      hi_raw = scol_type'({3'b0, ctr}) + scol_type'({5'b0, wdw});
      lo     = (lo_raw > ll_s) ? lo_raw : ll_s;
      hi     = (hi_raw < rl_s) ? hi_raw : rl_s;

      sreq.go  = 1'b0;
      sreq.row = y_ff;
      case (state_ff)
         FSM_SEED_R: begin
            sreq.pat = PAT_SEED_R; sreq.c0 = scol_type'({3'b0, start_col});
            sreq.bound = rl_s;
         end
         FSM_SEED_L: begin
            sreq.pat = PAT_SEED_L; sreq.c0 = scol_type'({3'b0, start_col});
            sreq.bound = ll_s;
         end
         FSM_TRK_L: begin sreq.pat = PAT_TRK_L; sreq.c0 = hi; sreq.bound = lo; end
         FSM_REF_L: begin sreq.pat = PAT_TRK_L; sreq.c0 = hi; sreq.bound = lo; end
         FSM_CTR_L: begin
            sreq.pat = PAT_CTR_L; sreq.c0 = scol_type'({3'b0, START_CENTER});
            sreq.bound = ll_s;
         end
         FSM_TRK_R: begin sreq.pat = PAT_TRK_R; sreq.c0 = lo; sreq.bound = hi; end
         FSM_REF_R: begin sreq.pat = PAT_TRK_R; sreq.c0 = lo; sreq.bound = hi; end
         default: begin
            sreq.pat = PAT_CTR_R; sreq.c0 = scol_type'({3'b0, START_CENTER});
            sreq.bound = rl_s;
         end
      endcase

      state_in     = state_ff;
      launched_in  = launched_ff;
      cl_in        = cl_ff;
      cr_in        = cr_ff;
      cnt_row_in   = cnt_row_ff;
      cnt_j_in     = cnt_j_ff;
      cnt_side_in  = cnt_side_ff;
      cnt_pend_in  = 1'b0;
      cnt_pside_in = cnt_pside_ff;
      y_in         = y_ff;
      el_in        = el_ff;
      er_in        = er_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      suml_in      = suml_ff;
      sumr_in      = sumr_ff;
      below_l_in   = below_l_ff;
      below_r_in   = below_r_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      lbase_in     = lbase_ff;
      rbase_in     = rbase_ff;
      inb_in       = inb_ff;
      rd_pend_in   = 1'b0;
      rd_oor_in    = rd_oor_ff;
      pix_en       = scan_re;
      pix_we       = 1'b0;
      pix_a        = scan_ra;
      pix_wd       = req_black;
      edge_en      = 1'b0;
      edge_we      = 1'b0;
      edge_a       = y_ff;
      edge_wd      = '{el_ff, er_ff, sl_ff, sr_ff};
      valid_set    = 1'b0;

      // counting reads land in the cycle after their address
      if (cnt_pend_ff && pix_q) begin
         if (cnt_pside_ff) begin
            cr_in = cr_ff + 6'd1;
         end else begin
            cl_in = cl_ff + 6'd1;
         end
      end

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               if (req_op) begin
                  rd_pend_in = 1'b1;
                  rd_oor_in  = (req_row >= 7'(IMG_HEIGHT));
                  edge_a     = req_row;
                  edge_en    = (req_row < 7'(IMG_HEIGHT));
               end else begin
                  pix_we = (req_row < 7'(IMG_HEIGHT)) && (req_col < 8'(IMG_WIDTH));
                  pix_en = pix_we;
                  pix_a  = pix_addr(req_row, req_col);
                  if (req_frame_done) begin
                     cl_in       = '0;
                     cr_in       = '0;
                     cnt_row_in  = '0;
                     cnt_j_in    = '0;
                     cnt_side_in = 1'b0;
                     state_in    = FSM_CNT;
                  end
               end
            end
         end
         FSM_CNT: begin
            pix_en       = 1'b1;
            pix_a        = pix_addr(7'(IMG_HEIGHT - 1) - {5'b0, cnt_row_ff}, cnt_col);
            cnt_pend_in  = 1'b1;
            cnt_pside_in = cnt_side_ff;
            cnt_side_in  = !cnt_side_ff;
            if (cnt_side_ff) begin
               if (cnt_j_ff == CNT_LAST_STEP) begin
                  cnt_j_in   = '0;
                  cnt_row_in = cnt_row_ff + 2'd1;
                  if (cnt_row_ff == CNT_LAST_ROW) begin
                     state_in = FSM_CNT_END;
                  end
               end else begin
                  cnt_j_in = cnt_j_ff + 5'd1;
               end
            end
         end
         FSM_CNT_END: begin
            y_in     = 7'(IMG_HEIGHT - 1);
            suml_in  = '0;
            sumr_in  = '0;
            state_in = FSM_SEED_RD;
         end
         FSM_SEED_RD: begin
            edge_en  = 1'b1;
            state_in = FSM_SEED_R;
         end
         FSM_SEED_R: begin
            if (!launched_ff) begin
               sreq.go     = 1'b1;
               launched_in = 1'b1;
               // a seed row that finds nothing keeps what it had
               el_in = ent.left_edge;
               er_in = ent.right_edge;
               sl_in = ent.left_status;
               sr_in = ent.right_status;
            end else if (srsp.done) begin
               launched_in = 1'b0;
               if (srsp.found) begin
                  er_in = 8'(srsp.x - scol_type'(1));
                  sr_in = ST_FOUND;
               end
               state_in = FSM_SEED_L;
            end
         end
         FSM_SEED_L: begin
            if (!launched_ff) begin
               sreq.go     = 1'b1;
               launched_in = 1'b1;
            end else if (srsp.done) begin
               launched_in = 1'b0;
               if (srsp.found) begin
                  el_in = 8'(srsp.x + scol_type'(1));
                  sl_in = ST_FOUND;
               end
               state_in = FSM_SEED_WR;
            end
         end
         FSM_SEED_WR: begin
            edge_en    = 1'b1;
            edge_we    = 1'b1;
            valid_set  = 1'b1;
            suml_in    = suml_ff + 10'(el_ff);
            sumr_in    = sumr_ff + 10'(er_ff);
            below_l_in = el_ff;
            below_r_in = er_ff;
            if (y_ff == SEED_LAST_ROW) begin
               state_in = FSM_BASE;
            end else begin
               y_in     = y_ff - 7'd1;
               state_in = FSM_SEED_RD;
            end
         end
         FSM_BASE: begin
            lbase_in  = lprod[DIV3_SHIFT +: 8];
            rbase_in  = rprod[DIV3_SHIFT +: 8];
            prev_l_in = lprod[DIV3_SHIFT +: 8];
            prev_r_in = rprod[DIV3_SHIFT +: 8];
            y_in      = TRACK_FIRST_ROW;
            state_in  = (top_row_ff > TRACK_FIRST_ROW) ? FSM_FINISH : FSM_TRK_L;
         end
         FSM_TRK_L, FSM_REF_L, FSM_CTR_L: begin
            if (!launched_ff) begin
               sreq.go     = 1'b1;
               launched_in = 1'b1;
            end else if (srsp.done) begin
               launched_in = 1'b0;
               if (srsp.found) begin
                  el_in     = 8'(srsp.x + scol_type'(2));
                  prev_l_in = 8'(srsp.x + scol_type'(2));
                  sl_in     = ST_FOUND;
                  state_in  = FSM_TRK_R;
               end else if (state_ff == FSM_TRK_L) begin
                  state_in = FSM_REF_L;
               end else if (state_ff == FSM_REF_L && center_ok) begin
                  state_in = FSM_CTR_L;
               end else begin
                  state_in = FSM_LOST_L;
               end
            end
         end
         FSM_LOST_L: begin
            inb_in   = in_frame(scol_type'({3'b0, below_l_ff}));
            pix_en   = 1'b1;
            pix_a    = inb_in ? pix_addr(y_ff, below_l_ff) : '0;
            state_in = FSM_LOST_LW;
         end
         FSM_LOST_LW: begin
            sl_in     = (inb_ff && pix_q) ? ST_LOST_BLACK : ST_LOST_WHITE;
            el_in     = below_l_ff;
            prev_l_in = below_l_ff;
            state_in  = FSM_TRK_R;
         end
         FSM_TRK_R, FSM_REF_R, FSM_CTR_R: begin
            if (!launched_ff) begin
               sreq.go     = 1'b1;
               launched_in = 1'b1;
            end else if (srsp.done) begin
               launched_in = 1'b0;
               if (srsp.found) begin
                  er_in     = 8'(srsp.x - scol_type'(2));
                  prev_r_in = 8'(srsp.x - scol_type'(2));
                  sr_in     = ST_FOUND;
                  state_in  = FSM_ROW_WR;
               end else if (state_ff == FSM_TRK_R) begin
                  state_in = FSM_REF_R;
               end else if (state_ff == FSM_REF_R && center_ok) begin
                  state_in = FSM_CTR_R;
               end else begin
                  state_in = FSM_LOST_R;
               end
            end
         end
         FSM_LOST_R: begin
            inb_in   = in_frame(scol_type'({3'b0, below_r_ff}));
            pix_en   = 1'b1;
            pix_a    = inb_in ? pix_addr(y_ff, below_r_ff) : '0;
            state_in = FSM_LOST_RW;
         end
         FSM_LOST_RW: begin
            sr_in     = (inb_ff && pix_q) ? ST_LOST_BLACK : ST_LOST_WHITE;
            er_in     = below_r_ff;
            prev_r_in = below_r_ff;
            state_in  = FSM_ROW_WR;
         end
         FSM_ROW_WR: begin
            edge_en    = 1'b1;
            edge_we    = 1'b1;
            valid_set  = 1'b1;
            below_l_in = el_ff;
            below_r_in = er_ff;
            if (y_ff == top_row_ff) begin
               state_in = FSM_FINISH;
            end else begin
               y_in     = y_ff - 7'd1;
               state_in = FSM_TRK_L;
            end
         end
         FSM_FINISH: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      rd_vld_in = rd_vld_ff;
      if (edge_en && !edge_we) begin
         rd_vld_in = valid_ff[edge_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FSM_IDLE;
         launched_ff <= 1'b0;
         cnt_pend_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         prev_l_ff   <= '0;
         prev_r_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         cnt_pend_ff <= cnt_pend_in;
         rd_pend_ff  <= rd_pend_in;
         prev_l_ff   <= prev_l_in;
         prev_r_ff   <= prev_r_in;
      end
   end

   always_ff @(posedge clock) begin
      cl_ff        <= cl_in;
      cr_ff        <= cr_in;
      cnt_row_ff   <= cnt_row_in;
      cnt_j_ff     <= cnt_j_in;
      cnt_side_ff  <= cnt_side_in;
      cnt_pside_ff <= cnt_pside_in;
      y_ff         <= y_in;
      el_ff        <= el_in;
      er_ff        <= er_in;
      sl_ff        <= sl_in;
      sr_ff        <= sr_in;
      suml_ff      <= suml_in;
      sumr_ff      <= sumr_in;
      below_l_ff   <= below_l_in;
      below_r_ff   <= below_r_in;
      lbase_ff     <= lbase_in;
      rbase_ff     <= rbase_in;
      inb_ff       <= inb_in;
      rd_oor_ff    <= rd_oor_in;
      rd_vld_ff    <= rd_vld_in;
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IMG_HEIGHT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (valid_set) begin
         valid_ff[y_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_limit_ff    <= 6'd5;
         right_limit_ff   <= 8'd155;
         top_row_ff       <= 7'd24;
         track_window_ff  <= 6'd10;
         refind_window_ff <= 6'd22;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEFT_LIMIT:    left_limit_ff    <= csr_wdata[5:0];
            CSR_RIGHT_LIMIT:   right_limit_ff   <= csr_wdata;
            CSR_TOP_ROW:       top_row_ff       <= csr_wdata[6:0];
            CSR_TRACK_WINDOW:  track_window_ff  <= csr_wdata[5:0];
            CSR_REFIND_WINDOW: refind_window_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_strobe          = rd_pend_ff || (state_ff == FSM_FINISH);
      rsp_is_frame_result = (state_ff == FSM_FINISH);
      if (state_ff == FSM_FINISH) begin
         rsp_left_edge    = lbase_ff;
         rsp_right_edge   = rbase_ff;
         rsp_left_status  = ST_FOUND;
         rsp_right_status = ST_FOUND;
      end else if (rd_oor_ff || !rd_vld_ff) begin
         rsp_left_edge    = '0;
         rsp_right_edge   = '0;
         rsp_left_status  = ST_FOUND;
         rsp_right_status = ST_FOUND;
      end else begin
         rsp_left_edge    = edge_q.left_edge;
         rsp_right_edge   = edge_q.right_edge;
         rsp_left_status  = edge_q.left_status;
         rsp_right_status = edge_q.right_status;
      end
   end

   `BLET_NEVER(a_scan_idle, clock, reset, srsp.busy && !busy)
   `BLET_ASSERT(a_read_rsp, clock, reset, start && !busy && req_op |=> rsp_strobe && !rsp_is_frame_result)
   `BLET_ASSERT(a_plain_wr, clock, reset, start && !busy && !req_op && !req_frame_done |=> !rsp_strobe)
   `BLET_ASSERT(a_frame_busy, clock, reset, start && !busy && !req_op && req_frame_done |=> busy)

endmodule
